/* src/ising_pkg.sv */
// shared types and constants of the ising site update block
// no dependencies; imported by the top level
package ising_pkg;

  // lattice geometry
  localparam int SIDE_MAX = 64;
  localparam int SIDE_W   = (SIDE_MAX > 2) ? $clog2(SIDE_MAX) : 1;
  localparam int ADDR_W   = 3 * SIDE_W;

  // field and register widths
  localparam int EXT_W   = 7;
  localparam int COORD_W = 6;
  localparam int THR_W   = 33;
  localparam int RAND_W  = 32;
  localparam int SWEEP_W = 32;

  // coordinate remainder unit: bits consumed per cycle, cycles per item
  localparam int MOD_PER = 3;
  localparam int MOD_CYC = (COORD_W + MOD_PER - 1) / MOD_PER;
  localparam int MODC_W  = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

  // random fraction width and comparison alignment
  localparam int RAND_BITS = 32;
  localparam int R_SH      = (RAND_BITS < 32) ? 32 - RAND_BITS : 0;
  localparam int T_SH      = (RAND_BITS >= 32) ? RAND_BITS - 32 : 0;
  localparam int CMP_W     = THR_W + T_SH;
  localparam logic [RAND_W-1:0] RAND_MASK =
    (RAND_BITS >= 32) ? {RAND_W{1'b1}} : RAND_W'((64'd1 << RAND_BITS) - 64'd1);

  // threshold meaning always flip
  localparam logic [THR_W-1:0] THR_ONE = THR_W'(64'd1 << 32);

  // item kinds
  typedef enum logic [1:0] {
    REQ_WRITE_SPIN = 2'd0,
    REQ_READ_SPIN  = 2'd1,
    REQ_WRITE_THR  = 2'd2,
    REQ_UPDATE     = 2'd3
  } req_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_THREE_D = 2'd0,
    CFG_SIZE_X  = 2'd1,
    CFG_SIZE_Y  = 2'd2,
    CFG_SIZE_Z  = 2'd3
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_READ,
    S_WRITE,
    S_EVAL,
    S_RESULT
  } state_t;

endpackage

/* src/ising_spin_ram.sv */
// single-port synchronous lattice memory, read data registered
// standalone generic ram, no package needed
module ising_spin_ram #(
  parameter int ADDR_W = 18,
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];

  // write, read-first registered port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/ising_metropolis_site_update.sv */
// Metropolis single-spin-flip site update of a 2D/3D Ising lattice, periodic wrap.
// One item is taken at a time: the coordinates are first reduced modulo the lattice
// extents, then the single lattice memory port reads one site per cycle.
// An update reads the centre and then its 4 or 6 neighbours one by one, evaluates
// with an optional write-back, then presents its result; a spin read reads the centre
// only, a spin write writes it, and a threshold write goes from the reduction to the result.
// The result register lets the next beat in while a result still waits. The lattice
// and the threshold table are undefined until written; no clearing pass runs.
// Depends on ising_pkg and ising_spin_ram.
module ising_metropolis_site_update (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [ising_pkg::EXT_W-1:0]  cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   req_type,
  input  logic [ising_pkg::COORD_W-1:0] site_x,
  input  logic [ising_pkg::COORD_W-1:0] site_y,
  input  logic [ising_pkg::COORD_W-1:0] site_z,
  input  logic                         spin_in,
  input  logic [3:0]                   table_index,
  input  logic [ising_pkg::THR_W-1:0]  threshold_in,
  input  logic [ising_pkg::RAND_W-1:0] rand_value,
  input  logic                         end_of_sweep,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         spin_out,
  output logic                         flipped,
  output logic [ising_pkg::SWEEP_W-1:0] sweeps_done
);
  import ising_pkg::*;

  // neighbour read order
  localparam logic [2:0] NB_CENTRE = 3'd0;
  localparam logic [2:0] NB_XUP    = 3'd1;
  localparam logic [2:0] NB_XDOWN  = 3'd2;
  localparam logic [2:0] NB_YUP    = 3'd3;
  localparam logic [2:0] NB_YDOWN  = 3'd4;
  localparam logic [2:0] NB_ZUP    = 3'd5;
  localparam logic [2:0] NB_ZDOWN  = 3'd6;

  state_t state, state_next;

  // configuration registers
  logic             three_d;
  logic [EXT_W-1:0] size_x, size_y, size_z;
  logic [EXT_W-1:0] nx, ny, nz;

  // captured item
  req_t              req_r;
  logic              eos_r;
  logic [RAND_W-1:0] rand_r;
  logic [COORD_W-1:0] cx, cy, cz;
  logic [COORD_W-1:0] cx_next, cy_next, cz_next;
  logic [EXT_W-1:0]  rem_x, rem_y, rem_z;
  logic [EXT_W-1:0]  rem_x_next, rem_y_next, rem_z_next;
  logic [MODC_W-1:0] mod_cnt;

  // read sequencing and collected values
  logic [2:0] rd_sel;
  logic [2:0] rd_pidx;
  logic       rd_pend;
  logic [2:0] n_reads;
  logic       spin;
  logic       flip;
  logic [2:0] count;

  // threshold table, undefined until written
  logic [THR_W-1:0] accept_table [16];
  logic [THR_W-1:0] thr_clamped;
  logic [THR_W-1:0] thr_sel;
  logic [CMP_W-1:0] cmp_lhs, cmp_rhs;
  logic             accept;

  // sweep counter
  logic [SWEEP_W-1:0] sweep_count;
  logic [SWEEP_W-1:0] sweep_next;

  // memory port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_wdata;
  logic              mem_rdata;

  // neighbour coordinates
  logic [EXT_W-1:0]  x_up, x_dn, y_up, y_dn, z_up, z_dn;
  logic [ADDR_W-1:0] centre_addr, nb_addr;

  logic in_beat, out_beat, slot_free, mod_last;

  // clamp an extent register into 2..SIDE_MAX
  function automatic logic [EXT_W-1:0] eff_size(input logic [EXT_W-1:0] r);
    logic [EXT_W-1:0] e;
    if (r < EXT_W'(2)) begin
      e = EXT_W'(2);
    end else if (r > EXT_W'(SIDE_MAX)) begin
      e = EXT_W'(SIDE_MAX);
    end else begin
      e = r;
    end
    return e;
  endfunction

  // one restoring remainder step: bring in one bit, subtract once
  function automatic logic [EXT_W-1:0] mod_step(input logic [EXT_W-1:0] r,
                                                input logic b,
                                                input logic [EXT_W-1:0] n);
    logic [EXT_W:0] t;
    t = {r, b};
    if (t >= {1'b0, n}) begin
      t = t - {1'b0, n};
    end
    return t[EXT_W-1:0];
  endfunction

  function automatic logic [EXT_W-1:0] wrap_up(input logic [EXT_W-1:0] c,
                                               input logic [EXT_W-1:0] n);
    logic [EXT_W-1:0] u;
    u = c + EXT_W'(1);
    return (u >= n) ? '0 : u;
  endfunction

  function automatic logic [EXT_W-1:0] wrap_down(input logic [EXT_W-1:0] c,
                                                 input logic [EXT_W-1:0] n);
    return (c == '0) ? n - EXT_W'(1) : c - EXT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] site_addr(input logic [EXT_W-1:0] x,
                                                  input logic [EXT_W-1:0] y,
                                                  input logic [EXT_W-1:0] z);
    return (ADDR_W'(z) << (2 * SIDE_W)) | (ADDR_W'(y) << SIDE_W) | ADDR_W'(x);
  endfunction

  assign nx = eff_size(size_x);
  assign ny = eff_size(size_y);
  assign nz = eff_size(size_z);

  assign in_beat   = in_valid && !in_stall;
  assign out_beat  = out_valid && !out_stall;
  assign slot_free = !out_valid || !out_stall;
  assign mod_last  = (mod_cnt == MODC_W'(MOD_CYC - 1));
  assign n_reads   = (req_r == REQ_UPDATE) ? (three_d ? 3'd7 : 3'd5) : 3'd1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      three_d <= 1'b0;
      size_x  <= EXT_W'(64);
      size_y  <= EXT_W'(64);
      size_z  <= EXT_W'(64);
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THREE_D: three_d <= cfg_data[0];
        CFG_SIZE_X:  size_x  <= cfg_data;
        CFG_SIZE_Y:  size_y  <= cfg_data;
        CFG_SIZE_Z:  size_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  // remainder unit: MOD_PER bits of each coordinate per cycle
  always_comb begin
    logic [EXT_W-1:0]   rx, ry, rz;
    logic [COORD_W-1:0] sx, sy, sz;
    rx = rem_x;
    ry = rem_y;
    rz = rem_z;
    sx = cx;
    sy = cy;
    sz = cz;
    for (int i = 0; i < MOD_PER; i++) begin
      rx = mod_step(rx, sx[COORD_W-1], nx);
      ry = mod_step(ry, sy[COORD_W-1], ny);
      rz = mod_step(rz, sz[COORD_W-1], nz);
      sx = sx << 1;
      sy = sy << 1;
      sz = sz << 1;
    end
    rem_x_next = rx;
    rem_y_next = ry;
    rem_z_next = rz;
    cx_next    = sx;
    cy_next    = sy;
    cz_next    = sz;
  end

  // neighbour addresses
  always_comb begin
    x_up = wrap_up(rem_x, nx);
    x_dn = wrap_down(rem_x, nx);
    y_up = wrap_up(rem_y, ny);
    y_dn = wrap_down(rem_y, ny);
    z_up = wrap_up(rem_z, nz);
    z_dn = wrap_down(rem_z, nz);
    centre_addr = site_addr(rem_x, rem_y, rem_z);
    unique case (rd_sel)
      NB_XUP:   nb_addr = site_addr(x_up, rem_y, rem_z);
      NB_XDOWN: nb_addr = site_addr(x_dn, rem_y, rem_z);
      NB_YUP:   nb_addr = site_addr(rem_x, y_up, rem_z);
      NB_YDOWN: nb_addr = site_addr(rem_x, y_dn, rem_z);
      NB_ZUP:   nb_addr = site_addr(rem_x, rem_y, z_up);
      NB_ZDOWN: nb_addr = site_addr(rem_x, rem_y, z_dn);
      default:  nb_addr = centre_addr;
    endcase
  end

  // threshold clamp and acceptance test
  always_comb begin
    thr_clamped = (threshold_in > THR_ONE) ? THR_ONE : threshold_in;
    thr_sel     = accept_table[{spin, count}];
    cmp_lhs     = CMP_W'(rand_r) << R_SH;
    cmp_rhs     = CMP_W'(thr_sel) << T_SH;
    accept      = (cmp_lhs < cmp_rhs);
  end

  // saturating sweep count
  always_comb begin
    sweep_next = sweep_count;
    if (req_r == REQ_UPDATE && eos_r && sweep_count != {SWEEP_W{1'b1}}) begin
      sweep_next = sweep_count + SWEEP_W'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_beat) state_next = S_MOD;
      end
      S_MOD: begin
        if (mod_last) begin
          unique case (req_r)
            REQ_WRITE_SPIN: state_next = S_WRITE;
            REQ_READ_SPIN:  state_next = S_READ;
            REQ_WRITE_THR:  state_next = S_RESULT;
            REQ_UPDATE:     state_next = S_READ;
          endcase
        end
      end
      S_READ: begin
        if (rd_sel == n_reads) begin
          state_next = (req_r == REQ_UPDATE) ? S_EVAL : S_RESULT;
        end
      end
      S_WRITE:  state_next = S_RESULT;
      S_EVAL:   state_next = S_RESULT;
      S_RESULT: begin
        if (slot_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // state-driven outputs and memory controls
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_addr  = centre_addr;
    mem_wdata = spin;
    unique case (state)
      S_IDLE:  in_stall = 1'b0;
      S_READ:  mem_addr = nb_addr;
      S_WRITE: mem_we = 1'b1;
      S_EVAL: begin
        mem_we    = accept;
        mem_wdata = !spin;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture, remainder iterations, read collection, evaluation
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
      rd_sel  <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            req_r   <= req_t'(req_type);
            eos_r   <= end_of_sweep;
            rand_r  <= rand_value & RAND_MASK;
            spin    <= spin_in;
            flip    <= 1'b0;
            count   <= '0;
            cx      <= site_x;
            cy      <= site_y;
            cz      <= three_d ? site_z : '0;
            rem_x   <= '0;
            rem_y   <= '0;
            rem_z   <= '0;
            mod_cnt <= '0;
            rd_sel  <= '0;
            rd_pend <= 1'b0;
            if (req_t'(req_type) == REQ_WRITE_THR) begin
              accept_table[table_index] <= thr_clamped;
            end
          end
        end
        S_MOD: begin
          rem_x   <= rem_x_next;
          rem_y   <= rem_y_next;
          rem_z   <= rem_z_next;
          cx      <= cx_next;
          cy      <= cy_next;
          cz      <= cz_next;
          mod_cnt <= mod_cnt + MODC_W'(1);
        end
        S_READ: begin
          // one site issued per cycle, its data collected in the next cycle
          if (rd_sel != n_reads) begin
            rd_pend <= 1'b1;
            rd_pidx <= rd_sel;
            rd_sel  <= rd_sel + 3'd1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            if (rd_pidx == NB_CENTRE) begin
              spin <= mem_rdata;
            end else begin
              count <= count + {2'b00, mem_rdata};
            end
          end
        end
        S_EVAL: begin
          if (accept) begin
            spin <= !spin;
            flip <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      sweep_count <= '0;
    end else if (state == S_RESULT && slot_free) begin
      out_valid   <= 1'b1;
      spin_out    <= (req_r == REQ_WRITE_THR) ? 1'b0 : spin;
      flipped     <= flip;
      sweeps_done <= sweep_next;
      sweep_count <= sweep_next;
    end else if (out_beat) begin
      out_valid <= 1'b0;
    end
  end

  ising_spin_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (1)
  ) u_lattice (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // checks
  a_result_from_result_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RESULT)
    else $error("result beat raised outside the result state");

  a_sweep_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> sweep_count >= $past(sweep_count))
    else $error("sweep counter went backwards");

  a_count_2d: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (count <= (three_d ? 3'd6 : 3'd4)))
    else $error("neighbour count above neighbour number");

  a_flip_only_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && flipped |-> $past(req_r) == REQ_UPDATE)
    else $error("flip reported on an item that is not an update");

  a_coord_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (rem_x < nx) && (rem_y < ny) && (rem_z < nz))
    else $error("coordinate not reduced below its extent");

endmodule
